// ===== hw/rtl/wrf_pkg.sv =====
// wrf_pkg: shared types and codes of the windowed event rate filter
// request structs, tracker entry layout, mode and register codes
// no dependencies
`default_nettype none

package wrf_pkg;

  localparam int CNT_W  = 31;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 10;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // filter modes
  localparam logic [MODE_W-1:0] MODE_DETECT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LIMIT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THRESHOLD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd2;

  // reset values of the registers
  localparam logic [MODE_W-1:0] FILTER_MODE_RESET    = MODE_LIMIT;
  localparam logic [CNT_W-1:0]  COUNT_LIMIT_RESET    = 31'd1;
  localparam logic [TIME_W-1:0] WINDOW_SECONDS_RESET = 32'd60;

  typedef struct packed {
    logic [IDX_W-1:0]  tracker_index;
    logic [TIME_W-1:0] now_seconds;
  } in_req_t;

  typedef struct packed {
    logic log_event;
    logic first_seen;
  } out_req_t;

  // one tracker table word
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  prev;
    logic [TIME_W-1:0] tstart;
    logic [TIME_W-1:0] tlast;
  } entry_t;

  // verdict plus the word to write back
  typedef struct packed {
    logic   log_event;
    entry_t entry;
  } judge_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wrf_table.sv =====
// wrf_table: tracker table, one write port and one registered read port
// depends on wrf_pkg for the entry layout
`default_nettype none

module wrf_table #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wrf_pkg::entry_t      wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output wrf_pkg::entry_t      rd_data
);
  import wrf_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wrf_judge.sv =====
// wrf_judge: count update and verdict for one tracker entry
// depends on wrf_pkg for entry, result and mode codes
`default_nettype none

module wrf_judge (
  input  wrf_pkg::entry_t                   src,
  input  wire logic [wrf_pkg::TIME_W-1:0]   now,
  input  wire logic [wrf_pkg::MODE_W-1:0]   filter_mode,
  input  wire logic [wrf_pkg::CNT_W-1:0]    count_limit,
  input  wire logic [wrf_pkg::TIME_W-1:0]   window_seconds,
  output wrf_pkg::judge_res_t               res
);
  import wrf_pkg::*;

  entry_t            fresh;
  entry_t            t;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] dlast;
  logic              expired;
  logic              log_event;

  // starting point: a fresh entry, or the stored one with a saturating count
  always_comb begin
    fresh = '{valid: 1'b1, cnt: CNT_W'(1), prev: '0, tstart: now, tlast: now};
    if (!src.valid) begin
      t = fresh;
    end else begin
      t = src;
      if (src.cnt != CNT_MAX) begin
        t.cnt = src.cnt + CNT_W'(1);
      end
    end
  end

  assign dt      = now - t.tstart;
  assign dlast   = now - t.tlast;
  assign expired = (dt >= window_seconds);

  // mode-specific window handling and verdict
  always_comb begin
    res       = '{log_event: 1'b1, entry: t};
    log_event = 1'b1;
    case (filter_mode)
      MODE_DETECT: begin
        if (expired) begin
          res.entry.tstart = now;
          res.entry.prev   = (dlast > window_seconds) ? '0 : t.cnt - CNT_W'(1);
          res.entry.cnt    = CNT_W'(1);
        end
        res.entry.tlast = now;
        log_event = (res.entry.cnt > count_limit) || (res.entry.prev > count_limit);
      end
      MODE_LIMIT: begin
        if (expired) begin
          res.entry.tstart = now;
          res.entry.cnt    = CNT_W'(1);
        end
        log_event = (res.entry.cnt <= count_limit);
      end
      MODE_THRESHOLD: begin
        if (expired) begin
          res.entry.tstart = now;
          res.entry.cnt    = CNT_W'(1);
        end
        if (res.entry.cnt >= count_limit) begin
          res.entry.cnt    = '0;
          res.entry.tstart = now;
          log_event = 1'b1;
        end else begin
          log_event = 1'b0;
        end
      end
      MODE_BOTH: begin
        if (expired) begin
          res.entry.tstart = now;
          res.entry.cnt    = CNT_W'(1);
          log_event = 1'b0;
        end else begin
          log_event = (res.entry.cnt == count_limit);
        end
      end
      default: begin
        log_event = 1'b1;
      end
    endcase
    // a new entry is stored as created; the mode's edits stay on the copy
    if (!src.valid) begin
      res.entry = fresh;
    end
    res.log_event = log_event;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_event_rate_filter_unit.sv =====
// windowed_event_rate_filter_unit: top level of the event rate filter
// depends on wrf_pkg, wrf_table and wrf_judge
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_write               cfg_index, cfg_data
//   in        in         in_valid / in_stall     in_req (in_req_t)
//   out       out        out_valid / out_stall   out_req (out_req_t)
//
// one request per cycle unless out_stall holds; lookup stage, then output register
// the tracker table has one read and one write port; a read that hits the
// entry written in the same cycle takes the written word by forwarding
// after reset a clearing pass over every table entry holds in_stall high
// a stalled output holds its request; one more request can wait behind it
`default_nettype none

module windowed_event_rate_filter_unit #(
  parameter int TRACKER_SLOTS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [wrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wrf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wrf_pkg::in_req_t                       in_req,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output wrf_pkg::out_req_t                      out_req
);
  import wrf_pkg::*;

  localparam int AW = $clog2(TRACKER_SLOTS);
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int CW = IW + 1;

  // configuration registers
  logic [MODE_W-1:0] filter_mode;
  logic [CNT_W-1:0]  count_limit;
  logic [TIME_W-1:0] window_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= FILTER_MODE_RESET;
      count_limit    <= COUNT_LIMIT_RESET;
      window_seconds <= WINDOW_SECONDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_MODE:    filter_mode    <= cfg_data[MODE_W-1:0];
        REG_COUNT_LIMIT:    count_limit    <= cfg_data[CNT_W-1:0];
        REG_WINDOW_SECONDS: window_seconds <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the table after reset
  logic          sweeping;
  logic [AW-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + AW'(1);
      if (sweep_addr == AW'(TRACKER_SLOTS - 1)) begin
        sweeping <= 1'b0;
      end
    end
  end

  // request decode
  logic [CW-1:0] idx_ext;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          in_active;
  logic          in_acc;

  assign idx_ext  = CW'(in_req.tracker_index);
  assign in_range = (idx_ext < CW'(TRACKER_SLOTS));
  assign in_addr  = idx_ext[AW-1:0];

  always_comb begin
    in_active = in_range && (filter_mode inside {[MODE_DETECT:MODE_BOTH]});
  end

  // lookup stage: table read in flight
  logic              a_valid;
  logic              a_active;
  logic [AW-1:0]     a_addr;
  logic [TIME_W-1:0] a_now;
  logic              fwd_valid;
  entry_t            fwd_word;
  logic              out_free;
  logic              a_done;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  entry_t            src;
  judge_res_t        jres;

  assign out_free = !out_valid || !out_stall;
  assign a_done   = a_valid && out_free;
  assign in_stall = sweeping || (a_valid && !out_free);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid   <= 1'b1;
      fwd_valid <= a_done && a_active && (a_addr == in_addr);
    end else if (a_done) begin
      a_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_active <= in_active;
      a_addr   <= in_addr;
      a_now    <= in_req.now_seconds;
      fwd_word <= jres.entry;
    end
  end

  // entry source: forwarded word on a back-to-back hit
  assign src = fwd_valid ? fwd_word : rd_data;

  wrf_judge u_judge (
    .src            (src),
    .now            (a_now),
    .filter_mode    (filter_mode),
    .count_limit    (count_limit),
    .window_seconds (window_seconds),
    .res            (jres)
  );

  // table write: clearing pass or write-back
  assign wr_en   = sweeping || (a_done && a_active);
  assign wr_addr = sweeping ? sweep_addr : a_addr;
  assign wr_data = sweeping ? '0 : jres.entry;

  wrf_table #(
    .DEPTH (TRACKER_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_done) begin
      if (a_active) begin
        out_req.log_event  <= jres.log_event;
        out_req.first_seen <= !src.valid;
      end else begin
        out_req.log_event  <= 1'b1;
        out_req.first_seen <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wrf_checker.sv =====
// wrf_checker: port-level assertions for the event rate filter top level
// depends on wrf_pkg; bound to windowed_event_rate_filter_unit below
`default_nettype none

module wrf_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cfg_write,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wrf_pkg::in_req_t                       in_req,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wrf_pkg::out_req_t                      out_req
);
  import wrf_pkg::*;

  // clearing pass blocks requests right after reset
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("in_stall low right after reset");

  // a new result must have an accepted request behind it
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching request");

  // register writes only while nothing is in flight
  assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !in_valid && !out_valid)
    else $error("register write with a request in flight");

  // stalled input request holds
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("stalled input request changed");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

endmodule

bind windowed_event_rate_filter_unit wrf_checker u_wrf_checker (.*);

`default_nettype wire

// ===== tb/windowed_event_rate_filter_unit_test.sv =====
`timescale 1ns / 100ps
// windowed_event_rate_filter_unit_test: self-checking bench for the event rate filter
// predicts every verdict from its own tracker table; needs wrf_pkg and the top level

module windowed_event_rate_filter_unit_test;
  import wrf_pkg::*;

  localparam int SLOTS = 1024;
  localparam int MAX_PRINTS = 40;
  // register index with no register behind it, and the highest unused mode code
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_req;

  // register copies and tracker table of the predictor
  logic [MODE_W-1:0] model_mode = FILTER_MODE_RESET;
  logic [CNT_W-1:0] model_limit = COUNT_LIMIT_RESET;
  logic [TIME_W-1:0] model_window = WINDOW_SECONDS_RESET;
  bit slot_valid [SLOTS];
  logic [CNT_W-1:0] slot_count [SLOTS];
  logic [CNT_W-1:0] slot_prior [SLOTS];
  logic [TIME_W-1:0] slot_start [SLOTS];
  logic [TIME_W-1:0] slot_last [SLOTS];

  in_req_t pending_events [$];
  out_req_t expected_verdicts [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  windowed_event_rate_filter_unit #(.TRACKER_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req(out_req)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t ERROR: %s", $time, what);
  endtask

  // verdict for one event; updates the tracker table as the block does
  function automatic out_req_t filter_verdict(input in_req_t ev);
    logic [IDX_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] last;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] prior;
    logic fresh;
    out_req_t res;
    slot = ev.tracker_index;
    now = ev.now_seconds;
    res.log_event = 1'b1;
    res.first_seen = 1'b0;
    // thresholding off, unused mode codes and slots past the table just log
    if (model_mode > MODE_BOTH || slot >= SLOTS) return res;
    fresh = !slot_valid[slot];
    if (fresh) begin
      // new tracker is stored as one event; mode changes stay on the scratch copy
      slot_valid[slot] = 1'b1;
      slot_count[slot] = CNT_W'(1);
      slot_prior[slot] = '0;
      slot_start[slot] = now;
      slot_last[slot] = now;
      cnt = CNT_W'(1);
      prior = '0;
      start = now;
      last = now;
    end else begin
      cnt = slot_count[slot];
      prior = slot_prior[slot];
      start = slot_start[slot];
      last = slot_last[slot];
      if (cnt != CNT_MAX) cnt = cnt + 1'b1;
    end
    elapsed = now - start;
    case (model_mode)
      MODE_DETECT: begin
        if (elapsed >= model_window) begin
          start = now;
          // a gap longer than the window forgets the old count
          if (now - last > model_window) prior = '0;
          else prior = cnt - 1'b1;
          cnt = CNT_W'(1);
        end
        last = now;
        res.log_event = (cnt > model_limit) || (prior > model_limit);
      end
      MODE_LIMIT: begin
        if (elapsed >= model_window) begin
          start = now;
          cnt = CNT_W'(1);
        end
        res.log_event = (cnt <= model_limit);
      end
      MODE_THRESHOLD: begin
        if (elapsed >= model_window) begin
          start = now;
          cnt = CNT_W'(1);
        end
        if (cnt >= model_limit) begin
          cnt = '0;
          start = now;
          res.log_event = 1'b1;
        end else begin
          res.log_event = 1'b0;
        end
      end
      MODE_BOTH: begin
        if (elapsed >= model_window) begin
          start = now;
          cnt = CNT_W'(1);
          res.log_event = 1'b0;
        end else begin
          res.log_event = (cnt == model_limit);
        end
      end
      default: res.log_event = 1'b1;
    endcase
    if (!fresh) begin
      slot_count[slot] = cnt;
      slot_prior[slot] = prior;
      slot_start[slot] = start;
      slot_last[slot] = last;
    end
    res.first_seen = fresh;
    return res;
  endfunction

  // follow register writes as the block sees them
  always @(posedge clk) begin
    if (rst) begin
      model_mode <= FILTER_MODE_RESET;
      model_limit <= COUNT_LIMIT_RESET;
      model_window <= WINDOW_SECONDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_MODE: model_mode <= cfg_data[MODE_W-1:0];
        REG_COUNT_LIMIT: model_limit <= cfg_data[CNT_W-1:0];
        REG_WINDOW_SECONDS: model_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // request driver: predict on accept, then present the next event or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_verdicts.push_back(filter_verdict(in_req));
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : result_check
    out_req_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result request with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_req.log_event !== want.log_event)
            report_mismatch($sformatf("log_event got %b want %b",
                                      out_req.log_event, want.log_event));
          if (out_req.first_seen !== want.first_seen)
            report_mismatch($sformatf("first_seen got %b want %b",
                                      out_req.first_seen, want.first_seen));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_event(input logic [IDX_W-1:0] slot, input logic [TIME_W-1:0] now);
    in_req_t ev;
    ev.tracker_index = slot;
    ev.now_seconds = now;
    pending_events.push_back(ev);
  endtask

  // wait until every event is accepted and every verdict has come back
  task automatic settle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_verdicts.size() != 0);
  endtask

  task automatic program_random_settings();
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0] limit;
    logic [TIME_W-1:0] window;
    if ($urandom_range(9) == 0) mode = MODE_W'($urandom_range(MODE_OFF, MODE_SPARE));
    else mode = MODE_W'($urandom_range(MODE_DETECT, MODE_BOTH));
    case ($urandom_range(9))
      0: limit = CNT_MAX;
      1: limit = CNT_W'($urandom());
      default: limit = CNT_W'($urandom_range(0, 4));
    endcase
    case ($urandom_range(9))
      0: window = '0;
      1: window = '1;
      2: window = $urandom();
      default: window = $urandom_range(1, 8);
    endcase
    write_reg(REG_FILTER_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, mode});
    write_reg(REG_COUNT_LIMIT, {1'b0, limit});
    write_reg(REG_WINDOW_SECONDS, window);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, $urandom());
  endtask

  initial begin
    int phase;
    int sub;
    int k;
    int pick;
    logic [TIME_W-1:0] clock_s;
    logic [IDX_W-1:0] hot [4];

    send_idle_pct = 8;
    recv_stall_pct = 79;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings (limit 1, window 60): new entries, repeat hits, time wrap
    add_event(10'd0, 32'd0);
    add_event(10'd0, 32'd10);
    add_event(10'd0, 32'd60);
    add_event(10'h3FF, 32'hFFFF_FFFF);
    add_event(10'h3FF, 32'd5);
    add_event(10'h3FF, 32'd59);
    add_event(10'h2AA, 32'hAAAA_AAAA);
    settle();

    // detect: window restart keeps the previous count, long gap clears it
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_DETECT));
    write_reg(REG_COUNT_LIMIT, 32'd1);
    write_reg(REG_WINDOW_SECONDS, 32'd4);
    for (k = 0; k < 5; k++) add_event(10'd5, 32'd100 + k);
    add_event(10'd5, 32'd120);
    settle();

    // threshold: log and clear at the limit, window restart
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_THRESHOLD));
    write_reg(REG_COUNT_LIMIT, 32'd2);
    write_reg(REG_WINDOW_SECONDS, 32'd100);
    for (k = 0; k < 4; k++) add_event(10'd6, k);
    add_event(10'd6, 32'd200);
    settle();

    // both, with the widest window: only the exact count logs
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_BOTH));
    write_reg(REG_COUNT_LIMIT, 32'd3);
    write_reg(REG_WINDOW_SECONDS, 32'hFFFF_FFFF);
    for (k = 0; k < 4; k++) add_event(10'd7, k);
    settle();

    // thresholding off, an unused mode code, a write to no register
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_OFF));
    add_event(10'd8, 32'd0);
    settle();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_SPARE));
    write_reg(REG_SPARE, 32'h1234_5678);
    add_event(10'd8, 32'd1);
    settle();

    // largest limit in limit mode
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_LIMIT));
    write_reg(REG_COUNT_LIMIT, {1'b0, CNT_MAX});
    add_event(10'd9, 32'd0);
    settle();

    // random part: bursts on a few hot trackers, some stray events and time jumps
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (sub = 0; sub < 4; sub++) begin
        program_random_settings();
        clock_s = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom();
        for (k = 0; k < 4; k++) hot[k] = IDX_W'($urandom_range(SLOTS - 1));
        for (k = 0; k < 33; k++) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            add_event(IDX_W'($urandom_range(SLOTS - 1)), $urandom());
          end else begin
            if (pick < 14) clock_s = clock_s + $urandom();
            else clock_s = clock_s + $urandom_range(0, 6);
            add_event(hot[$urandom_range(3)], clock_s);
          end
        end
        settle();
      end
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("windowed_event_rate_filter_unit: match");
    end else begin
      $display("windowed_event_rate_filter_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("windowed_event_rate_filter_unit: mismatch");
    $finish;
  end

endmodule

// ===== windowed_event_rate_filter_unit.f =====
hw/rtl/wrf_pkg.sv
hw/rtl/wrf_table.sv
hw/rtl/wrf_judge.sv
hw/rtl/windowed_event_rate_filter_unit.sv
hw/rtl/wrf_checker.sv
tb/windowed_event_rate_filter_unit_test.sv
